>>> rtl/core/bcie_pkg.sv
// Shared constants, types and range helper for the box cell index enumerator.
package bcie_pkg;

  // Field widths of the ports.
  localparam int COORD_W = 32;
  localparam int PAD_W   = 31;
  localparam int CELL_W  = 32;
  localparam int REG_W   = 3;

  // Placement of the axes in the packed cell word.
  localparam int X_SHIFT = 22;
  localparam int Y_SHIFT = 11;
  localparam int XF_W    = CELL_W - X_SHIFT;
  localparam int YF_W    = X_SHIFT - Y_SHIFT;
  localparam int ZF_W    = Y_SHIFT;
  localparam int FIELD_W = (YF_W > XF_W) ? YF_W : XF_W;

  // Default parameter values.
  localparam int MAX_SPAN_DEF = 4;
  localparam int X_BITS_DEF   = 10;
  localparam int Y_BITS_DEF   = 11;
  localparam int Z_BITS_DEF   = 11;

  // Datapath widths: offset, half-width partial product, full product, raw index.
  localparam int HALF_W = 16;
  localparam int D_W    = COORD_W + 2;
  localparam int M_W    = D_W + HALF_W + 1;
  localparam int P_W    = D_W + 2 * HALF_W;
  localparam int RAW_W  = P_W - 2 * HALF_W;

  // Depth of the queue between the front and back parts.
  localparam int Q_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [REG_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [REG_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [REG_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [REG_W-1:0] REG_INV_X    = 3'd3;
  localparam logic [REG_W-1:0] REG_INV_Y    = 3'd4;
  localparam logic [REG_W-1:0] REG_INV_Z    = 3'd5;
  localparam logic [REG_W-1:0] REG_PAD      = 3'd6;

  // Cell range of one box, as handed from the front part to the back part.
  typedef struct packed {
    logic [XF_W-1:0] xl;
    logic [XF_W-1:0] xh;
    logic [YF_W-1:0] yl;
    logic [YF_W-1:0] yh;
    logic [ZF_W-1:0] zl;
    logic [ZF_W-1:0] zh;
    logic            cut;
  } box_range_t;

  // Queue status seen by the two sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Clamped and span-limited range of one axis.
  typedef struct packed {
    logic               empty;
    logic [FIELD_W-1:0] lo;
    logic [FIELD_W-1:0] hi;
    logic               cut;
  } axis_range_t;

  // Clamp both raw indices to 0..top and limit the span to span cells.
  function automatic axis_range_t axis_range(input logic signed [RAW_W-1:0] rmin,
                                             input logic signed [RAW_W-1:0] rmax,
                                             input logic [FIELD_W-1:0] top,
                                             input logic [FIELD_W-1:0] span);
    axis_range_t              r;
    logic signed [RAW_W-1:0]  top_s;
    logic [FIELD_W-1:0]       a;
    logic [FIELD_W-1:0]       b;
    top_s = $signed({{(RAW_W-FIELD_W){1'b0}}, top});
    r.empty = (rmin > rmax);
    if (rmin[RAW_W-1]) begin
      a = '0;
    end else if (rmin > top_s) begin
      a = top;
    end else begin
      a = rmin[FIELD_W-1:0];
    end
    if (rmax[RAW_W-1]) begin
      b = '0;
    end else if (rmax > top_s) begin
      b = top;
    end else begin
      b = rmax[FIELD_W-1:0];
    end
    r.cut = ((b - a) >= span);
    r.lo  = a;
    r.hi  = r.cut ? (a + span - FIELD_W'(1)) : b;
    return r;
  endfunction

endpackage

>>> rtl/core/bcie_front.sv
// Front part: takes a box word, maps its corners to cell indices and queues the range.
module bcie_front #(
  parameter int MAX_SPAN = bcie_pkg::MAX_SPAN_DEF,
  parameter int X_BITS   = bcie_pkg::X_BITS_DEF,
  parameter int Y_BITS   = bcie_pkg::Y_BITS_DEF,
  parameter int Z_BITS   = bcie_pkg::Z_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [bcie_pkg::COORD_W-1:0]  box_min_x,
  input  logic signed [bcie_pkg::COORD_W-1:0]  box_min_y,
  input  logic signed [bcie_pkg::COORD_W-1:0]  box_min_z,
  input  logic signed [bcie_pkg::COORD_W-1:0]  box_max_x,
  input  logic signed [bcie_pkg::COORD_W-1:0]  box_max_y,
  input  logic signed [bcie_pkg::COORD_W-1:0]  box_max_z,
  input  logic signed [bcie_pkg::COORD_W-1:0]  origin_x,
  input  logic signed [bcie_pkg::COORD_W-1:0]  origin_y,
  input  logic signed [bcie_pkg::COORD_W-1:0]  origin_z,
  input  logic [bcie_pkg::COORD_W-1:0]         inv_cell_x,
  input  logic [bcie_pkg::COORD_W-1:0]         inv_cell_y,
  input  logic [bcie_pkg::COORD_W-1:0]         inv_cell_z,
  input  logic [bcie_pkg::PAD_W-1:0]           pad,
  input  bcie_pkg::q_status_t                  q_status,
  output logic                                 busy,
  output logic                                 push,
  output bcie_pkg::box_range_t                 push_data
);
  import bcie_pkg::*;

  localparam logic [FIELD_W-1:0] X_TOP = FIELD_W'((1 << X_BITS) - 1);
  localparam logic [FIELD_W-1:0] Y_TOP = FIELD_W'((1 << Y_BITS) - 1);
  localparam logic [FIELD_W-1:0] Z_TOP = FIELD_W'((1 << Z_BITS) - 1);
  localparam logic [FIELD_W-1:0] SPAN  = FIELD_W'(MAX_SPAN);
  localparam logic [1:0]         AXIS_LAST = 2'd2;

  typedef enum logic [5:0] {
    F_IDLE  = 6'b000001,
    F_DIFF  = 6'b000010,
    F_MLO   = 6'b000100,
    F_MHI   = 6'b001000,
    F_SUM   = 6'b010000,
    F_RANGE = 6'b100000
  } front_state_t;

  front_state_t              state, state_next;
  logic                      side;
  logic [1:0]                axis;
  logic signed [COORD_W-1:0] box [2][3];
  logic signed [RAW_W-1:0]   raw [2][3];
  logic signed [D_W-1:0]     d;
  logic signed [M_W-1:0]     plo;
  logic signed [M_W-1:0]     phi;

  logic signed [COORD_W-1:0] coord_sel;
  logic signed [COORD_W-1:0] origin_sel;
  logic [COORD_W-1:0]        inv_sel;
  logic signed [D_W-1:0]     d_next;
  logic [HALF_W-1:0]         half;
  logic signed [M_W-1:0]     prod;
  logic signed [P_W-1:0]     psum;
  axis_range_t               rx, ry, rz;
  logic                      accept;

  assign accept = start && !busy;
  assign busy   = (state != F_IDLE) || q_status.full;

  // Select the corner coordinate and the axis registers for this step.
  always_comb begin
    coord_sel = box[side][axis];
    case (axis)
      2'd0: begin
        origin_sel = origin_x;
        inv_sel    = inv_cell_x;
      end
      2'd1: begin
        origin_sel = origin_y;
        inv_sel    = inv_cell_y;
      end
      default: begin
        origin_sel = origin_z;
        inv_sel    = inv_cell_z;
      end
    endcase
  end

  // Offset from the origin, widened by the padding outward on each side.
  always_comb begin
    if (side) begin
      d_next = D_W'(coord_sel) - D_W'(origin_sel) + $signed({3'b000, pad});
    end else begin
      d_next = D_W'(coord_sel) - D_W'(origin_sel) - $signed({3'b000, pad});
    end
  end

  // One shared multiplier takes the low then the high half of the reciprocal.
  assign half = (state == F_MLO) ? inv_sel[HALF_W-1:0] : inv_sel[2*HALF_W-1:HALF_W];
  assign prod = d * $signed({1'b0, half});

  // Full product in Q32.32; keeping only its upper bits gives the floor.
  assign psum = ($signed({{(P_W-M_W){phi[M_W-1]}}, phi}) <<< HALF_W)
              + $signed({{(P_W-M_W){plo[M_W-1]}}, plo});

  // Clamp and span-limit all three axes once every corner is done.
  assign rx = axis_range(raw[0][0], raw[1][0], X_TOP, SPAN);
  assign ry = axis_range(raw[0][1], raw[1][1], Y_TOP, SPAN);
  assign rz = axis_range(raw[0][2], raw[1][2], Z_TOP, SPAN);

  assign push = (state == F_RANGE) && !rx.empty && !ry.empty && !rz.empty;

  always_comb begin
    push_data.xl  = rx.lo[XF_W-1:0];
    push_data.xh  = rx.hi[XF_W-1:0];
    push_data.yl  = ry.lo[YF_W-1:0];
    push_data.yh  = ry.hi[YF_W-1:0];
    push_data.zl  = rz.lo[ZF_W-1:0];
    push_data.zh  = rz.hi[ZF_W-1:0];
    push_data.cut = rx.cut || ry.cut || rz.cut;
  end

  // Sequencer over the six corners.
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:  if (accept) state_next = F_DIFF;
      F_DIFF:  state_next = F_MLO;
      F_MLO:   state_next = F_MHI;
      F_MHI:   state_next = F_SUM;
      F_SUM:   state_next = (side && axis == AXIS_LAST) ? F_RANGE : F_DIFF;
      F_RANGE: state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      side  <= 1'b0;
      axis  <= 2'd0;
    end else begin
      state <= state_next;
      if (accept) begin
        side <= 1'b0;
        axis <= 2'd0;
      end else if (state == F_SUM) begin
        if (axis == AXIS_LAST) begin
          axis <= 2'd0;
          side <= 1'b1;
        end else begin
          axis <= axis + 2'd1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      box[0][0] <= box_min_x;
      box[0][1] <= box_min_y;
      box[0][2] <= box_min_z;
      box[1][0] <= box_max_x;
      box[1][1] <= box_max_y;
      box[1][2] <= box_max_z;
    end
    if (state == F_DIFF) d <= d_next;
    if (state == F_MLO) plo <= prod;
    if (state == F_MHI) phi <= prod;
    if (state == F_SUM) raw[side][axis] <= psum[P_W-1:2*HALF_W];
  end

endmodule

>>> rtl/core/bcie_queue.sv
// Short queue of cell ranges between the front and back parts.
module bcie_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  bcie_pkg::box_range_t push_data,
  input  logic                 pop,
  output bcie_pkg::box_range_t pop_data,
  output bcie_pkg::q_status_t  q_status
);
  import bcie_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  box_range_t       entry [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_status.full  = (count == CNT_W'(Q_DEPTH));
  assign q_status.empty = (count == '0);
  assign pop_data       = entry[rd_ptr];

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

endmodule

>>> rtl/core/bcie_back.sv
// Back part: walks every cell of a queued range, one word per cycle.
module bcie_back (
  input  logic                          clk,
  input  logic                          rst,
  input  bcie_pkg::q_status_t           q_status,
  input  bcie_pkg::box_range_t          pop_data,
  output logic                          pop,
  output logic                          strobe,
  output logic [bcie_pkg::CELL_W-1:0]   cell_index,
  output logic                          last,
  output logic                          truncated
);
  import bcie_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_RUN  = 2'b10
  } back_state_t;

  back_state_t     state;
  box_range_t      rng;
  logic [XF_W-1:0] x;
  logic [YF_W-1:0] y;
  logic [ZF_W-1:0] z;
  logic            z_end, y_end, x_end, done;

  assign z_end = (z == rng.zh);
  assign y_end = (y == rng.yh);
  assign x_end = (x == rng.xh);
  assign done  = (state == B_RUN) && x_end && y_end && z_end;

  // Take the next range as soon as the current one finishes.
  assign pop = !q_status.empty && ((state == B_IDLE) || done);

  assign strobe     = (state == B_RUN);
  assign cell_index = {x, y, z};
  assign last       = done;
  assign truncated  = strobe && rng.cut;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      unique case (state)
        B_IDLE:  if (pop) state <= B_RUN;
        B_RUN:   if (done && !pop) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  // Counters: z innermost, x outermost.
  always_ff @(posedge clk) begin
    if (pop) begin
      rng <= pop_data;
      x   <= pop_data.xl;
      y   <= pop_data.yl;
      z   <= pop_data.zl;
    end else if (state == B_RUN && !done) begin
      if (z_end) begin
        z <= rng.zl;
        if (y_end) begin
          y <= rng.yl;
          x <= x + XF_W'(1);
        end else begin
          y <= y + YF_W'(1);
        end
      end else begin
        z <= z + ZF_W'(1);
      end
    end
  end

endmodule

>>> rtl/core/box_cell_index_enumerator.sv
// Top level of the box cell index enumerator: registers, front, queue and back.
//
//   Channel   Handshake              Payload
//   box in    start, busy            box_min_x/y/z, box_max_x/y/z
//   cells out strobe                 cell_index, last, truncated
//   config    wr_en                  wr_index, wr_data
//
// The front part takes a new box only in idle and while the queue is not full.
// For each corner it forms the offset, two half-width products on one shared
// multiplier and the sum; then it clamps and goes back to idle for the next box.
// The back part sends one word per cycle, up to MAX_SPAN cubed words per box;
// a two-entry queue lets the front work on the next box meanwhile.
// Reset is synchronous and clears the sequencers and the queue; the registers
// return to origin 0, reciprocal 1.0 and no padding. The receiver cannot stall.
module box_cell_index_enumerator #(
  parameter int MAX_SPAN = bcie_pkg::MAX_SPAN_DEF,
  parameter int X_BITS   = bcie_pkg::X_BITS_DEF,
  parameter int Y_BITS   = bcie_pkg::Y_BITS_DEF,
  parameter int Z_BITS   = bcie_pkg::Z_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [bcie_pkg::COORD_W-1:0] box_min_x,
  input  logic signed [bcie_pkg::COORD_W-1:0] box_min_y,
  input  logic signed [bcie_pkg::COORD_W-1:0] box_min_z,
  input  logic signed [bcie_pkg::COORD_W-1:0] box_max_x,
  input  logic signed [bcie_pkg::COORD_W-1:0] box_max_y,
  input  logic signed [bcie_pkg::COORD_W-1:0] box_max_z,
  output logic                                strobe,
  output logic [bcie_pkg::CELL_W-1:0]         cell_index,
  output logic                                last,
  output logic                                truncated,
  input  logic                                wr_en,
  input  logic [bcie_pkg::REG_W-1:0]          wr_index,
  input  logic [bcie_pkg::COORD_W-1:0]        wr_data
);
  import bcie_pkg::*;

  logic signed [COORD_W-1:0] origin_x, origin_y, origin_z;
  logic [COORD_W-1:0]        inv_cell_x, inv_cell_y, inv_cell_z;
  logic [PAD_W-1:0]          pad;

  logic                      push;
  logic                      pop;
  box_range_t                push_data;
  box_range_t                pop_data;
  q_status_t                 q_status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= '0;
      origin_y   <= '0;
      origin_z   <= '0;
      inv_cell_x <= COORD_W'(32'h0001_0000);
      inv_cell_y <= COORD_W'(32'h0001_0000);
      inv_cell_z <= COORD_W'(32'h0001_0000);
      pad        <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_ORIGIN_X: origin_x   <= wr_data;
        REG_ORIGIN_Y: origin_y   <= wr_data;
        REG_ORIGIN_Z: origin_z   <= wr_data;
        REG_INV_X:    inv_cell_x <= wr_data;
        REG_INV_Y:    inv_cell_y <= wr_data;
        REG_INV_Z:    inv_cell_z <= wr_data;
        REG_PAD:      pad        <= wr_data[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  bcie_front #(
    .MAX_SPAN (MAX_SPAN),
    .X_BITS   (X_BITS),
    .Y_BITS   (Y_BITS),
    .Z_BITS   (Z_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .box_min_x  (box_min_x),
    .box_min_y  (box_min_y),
    .box_min_z  (box_min_z),
    .box_max_x  (box_max_x),
    .box_max_y  (box_max_y),
    .box_max_z  (box_max_z),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .origin_z   (origin_z),
    .inv_cell_x (inv_cell_x),
    .inv_cell_y (inv_cell_y),
    .inv_cell_z (inv_cell_z),
    .pad        (pad),
    .q_status   (q_status),
    .busy       (busy),
    .push       (push),
    .push_data  (push_data)
  );

  bcie_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  bcie_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .pop_data   (pop_data),
    .pop        (pop),
    .strobe     (strobe),
    .cell_index (cell_index),
    .last       (last),
    .truncated  (truncated)
  );

  // The front part never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("range pushed into a full queue");

  // An accepted box keeps the front part busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("front part not busy after taking a box");

  // A box's words come in one unbroken run up to its last word.
  a_run_unbroken: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe)
    else $error("gap inside the words of one box");

  // The truncated flag holds for every word of one box.
  a_cut_steady: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> (truncated == $past(truncated)))
    else $error("truncated flag changed within one box");

endmodule

>>> tb/bcie_cell_monitor.sv
// Watches the enumerator's ports, predicts the cell words of every box and compares them.
module bcie_cell_monitor #(
  parameter int MAX_SPAN = bcie_pkg::MAX_SPAN_DEF,
  parameter int X_BITS   = bcie_pkg::X_BITS_DEF,
  parameter int Y_BITS   = bcie_pkg::Y_BITS_DEF,
  parameter int Z_BITS   = bcie_pkg::Z_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic signed [bcie_pkg::COORD_W-1:0] box_min_x,
  input  logic signed [bcie_pkg::COORD_W-1:0] box_min_y,
  input  logic signed [bcie_pkg::COORD_W-1:0] box_min_z,
  input  logic signed [bcie_pkg::COORD_W-1:0] box_max_x,
  input  logic signed [bcie_pkg::COORD_W-1:0] box_max_y,
  input  logic signed [bcie_pkg::COORD_W-1:0] box_max_z,
  input  logic                                strobe,
  input  logic [bcie_pkg::CELL_W-1:0]         cell_index,
  input  logic                                last,
  input  logic                                truncated,
  input  logic                                wr_en,
  input  logic [bcie_pkg::REG_W-1:0]          wr_index,
  input  logic [bcie_pkg::COORD_W-1:0]        wr_data,
  output int                                  mismatches,
  output int                                  cells_pending
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = bcie_pkg::CELL_W;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [CW-1:0] cidx;
    logic          last;
    logic          cut;
  } cell_word_t;

  typedef struct {
    bit     empty;
    longint lo;
    longint hi;
    bit     cut;
  } axis_cover_t;

  // Shadow copy of the configuration registers.
  longint      origin_q [3];
  logic [31:0] inv_q [3];
  longint      pad_q;

  cell_word_t expected_cells [$];
  cell_word_t head;
  int         mismatch_count = 0;

  assign mismatches = mismatch_count;

  // Prints one line per mismatch, up to a cap, and counts all of them.
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
  endtask

  // Exact floor of an offset times a Q16.16 reciprocal, giving a cell index.
  function automatic longint floor_scaled(input longint d, input logic [31:0] inv);
    logic signed [99:0] prod;
    prod = d * $signed({1'b0, inv});
    prod = prod >>> 32;
    return $signed(prod[63:0]);
  endfunction

  // Cell range that one axis of a box covers, clamped and span-limited.
  function automatic axis_cover_t cover_axis(input logic signed [31:0] cmin,
                                             input logic signed [31:0] cmax,
                                             input int axis);
    axis_cover_t r;
    longint      rmin;
    longint      rmax;
    longint      top;
    longint      a;
    longint      b;
    int          bits;
    bits = (axis == 0) ? X_BITS : (axis == 1) ? Y_BITS : Z_BITS;
    top  = (longint'(1) << bits) - 1;
    rmin = floor_scaled(longint'(cmin) - origin_q[axis] - pad_q, inv_q[axis]);
    rmax = floor_scaled(longint'(cmax) - origin_q[axis] + pad_q, inv_q[axis]);
    r.empty = (rmin > rmax);
    a = (rmin < 0) ? 0 : (rmin > top) ? top : rmin;
    b = (rmax < 0) ? 0 : (rmax > top) ? top : rmax;
    r.cut = (b - a + 1 > MAX_SPAN);
    if (r.cut) begin
      b = a + MAX_SPAN - 1;
    end
    r.lo = a;
    r.hi = b;
    return r;
  endfunction

  // Queues every cell word of one box, z innermost and x outermost.
  function automatic void enumerate_box_cells(input logic signed [31:0] mnx,
                                              input logic signed [31:0] mny,
                                              input logic signed [31:0] mnz,
                                              input logic signed [31:0] mxx,
                                              input logic signed [31:0] mxy,
                                              input logic signed [31:0] mxz);
    axis_cover_t cx;
    axis_cover_t cy;
    axis_cover_t cz;
    cell_word_t  w;
    cx = cover_axis(mnx, mxx, 0);
    cy = cover_axis(mny, mxy, 1);
    cz = cover_axis(mnz, mxz, 2);
    if (cx.empty || cy.empty || cz.empty) begin
      return;
    end
    for (longint x = cx.lo; x <= cx.hi; x++) begin
      for (longint y = cy.lo; y <= cy.hi; y++) begin
        for (longint z = cz.lo; z <= cz.hi; z++) begin
          w.cidx = (CW'(x) << bcie_pkg::X_SHIFT) | (CW'(y) << bcie_pkg::Y_SHIFT) | CW'(z);
          w.last = (x == cx.hi) && (y == cy.hi) && (z == cz.hi);
          w.cut  = cx.cut || cy.cut || cz.cut;
          expected_cells.insert(expected_cells.size(), w);
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      origin_q = '{0, 0, 0};
      inv_q    = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
      pad_q    = 0;
      expected_cells.delete();
    end else begin
      // Compare an emitted word with the oldest expected one.
      if (strobe) begin
        if (expected_cells.size() == 0) begin
          report_mismatch($sformatf("cell word %h with no box pending", cell_index));
        end else begin
          head = expected_cells.pop_front();
          if (cell_index !== head.cidx) begin
            report_mismatch($sformatf("cell_index %h, expected %h", cell_index, head.cidx));
          end
          if (last !== head.last) begin
            report_mismatch($sformatf("last %b, expected %b on cell %h",
                                      last, head.last, head.cidx));
          end
          if (truncated !== head.cut) begin
            report_mismatch($sformatf("truncated %b, expected %b on cell %h",
                                      truncated, head.cut, head.cidx));
          end
        end
      end
      // A box is taken when start meets a free block.
      if (start && !busy) begin
        enumerate_box_cells(box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z);
      end
      // Track register writes.
      if (wr_en) begin
        case (wr_index)
          bcie_pkg::REG_ORIGIN_X: origin_q[0] = longint'($signed(wr_data));
          bcie_pkg::REG_ORIGIN_Y: origin_q[1] = longint'($signed(wr_data));
          bcie_pkg::REG_ORIGIN_Z: origin_q[2] = longint'($signed(wr_data));
          bcie_pkg::REG_INV_X:    inv_q[0] = wr_data;
          bcie_pkg::REG_INV_Y:    inv_q[1] = wr_data;
          bcie_pkg::REG_INV_Z:    inv_q[2] = wr_data;
          bcie_pkg::REG_PAD:      pad_q = longint'(wr_data[bcie_pkg::PAD_W-1:0]);
          default: ;
        endcase
      end
    end
    cells_pending <= expected_cells.size();
  end

endmodule

>>> tb/box_cell_index_enumerator_tb.sv
// Top of the enumerator testbench: clock, reset, register settings and box stimulus.
module box_cell_index_enumerator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [31:0] lo [3];
    logic [31:0] hi [3];
  } box_t;

  logic                                clk;
  logic                                rst;
  logic                                start;
  logic                                busy;
  logic signed [bcie_pkg::COORD_W-1:0] box_min_x;
  logic signed [bcie_pkg::COORD_W-1:0] box_min_y;
  logic signed [bcie_pkg::COORD_W-1:0] box_min_z;
  logic signed [bcie_pkg::COORD_W-1:0] box_max_x;
  logic signed [bcie_pkg::COORD_W-1:0] box_max_y;
  logic signed [bcie_pkg::COORD_W-1:0] box_max_z;
  logic                                strobe;
  logic [bcie_pkg::CELL_W-1:0]         cell_index;
  logic                                last;
  logic                                truncated;
  logic                                wr_en;
  logic [bcie_pkg::REG_W-1:0]          wr_index;
  logic [bcie_pkg::COORD_W-1:0]        wr_data;
  int                                  mismatches;
  int                                  cells_pending;
  int                                  stall_cycles = 0;

  // Grid placement as currently programmed, used to aim boxes at the grid.
  longint grid_org [3] = '{0, 0, 0};
  longint cell_len [3] = '{65536, 65536, 65536};

  box_cell_index_enumerator dut (
    .clk, .rst, .start, .busy,
    .box_min_x, .box_min_y, .box_min_z, .box_max_x, .box_max_y, .box_max_z,
    .strobe, .cell_index, .last, .truncated,
    .wr_en, .wr_index, .wr_data
  );

  bcie_cell_monitor monitor (
    .clk, .rst, .start, .busy,
    .box_min_x, .box_min_y, .box_min_z, .box_max_x, .box_max_y, .box_max_z,
    .strobe, .cell_index, .last, .truncated,
    .wr_en, .wr_index, .wr_data,
    .mismatches, .cells_pending
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Ends the run when nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || wr_en) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] q16(input int cells);
    return cells << 16;
  endfunction

  function automatic int axis_bits(input int i);
    return (i == 0) ? bcie_pkg::X_BITS_DEF :
           (i == 1) ? bcie_pkg::Y_BITS_DEF : bcie_pkg::Z_BITS_DEF;
  endfunction

  // Approximate cell size in coordinate units for a reciprocal.
  function automatic longint cell_step(input logic [31:0] inv);
    longint s;
    if (inv == 0) begin
      return 65536;
    end
    s = (longint'(1) << 32) / longint'(inv);
    if (s < 1) s = 1;
    if (s > (longint'(1) << 30)) s = longint'(1) << 30;
    return s;
  endfunction

  // Mostly small boxes aimed at the grid and its borders; some noise and inverted axes.
  function automatic box_t make_box();
    box_t   b;
    int     kind;
    int     pick;
    longint top;
    longint slot;
    longint base;
    longint far;
    logic [31:0] tmp;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 3; i++) begin
      if (kind < 15) begin
        b.lo[i] = $urandom;
        b.hi[i] = $urandom;
      end else begin
        top  = (longint'(1) << axis_bits(i)) - 1;
        pick = $urandom_range(0, 4);
        if (pick == 0) begin
          slot = longint'($urandom_range(0, 3)) - 2;
        end else if (pick == 1) begin
          slot = top - 1 + longint'($urandom_range(0, 3));
        end else begin
          slot = longint'($urandom_range(0, int'(top)));
        end
        base = grid_org[i] + slot * cell_len[i] + longint'($urandom) % cell_len[i];
        far  = base + longint'($urandom_range(0, 4)) * cell_len[i]
               + longint'($urandom) % cell_len[i];
        b.lo[i] = base[31:0];
        b.hi[i] = far[31:0];
      end
    end
    // Turn one axis inside out now and then.
    if (kind >= 90) begin
      pick = $urandom_range(0, 2);
      tmp = b.lo[pick];
      b.lo[pick] = b.hi[pick];
      b.hi[pick] = tmp;
    end
    return b;
  endfunction

  // Presents one box and holds it until the block takes the word.
  task automatic send_box(input box_t b);
    start     <= 1'b1;
    box_min_x <= b.lo[0];
    box_min_y <= b.lo[1];
    box_min_z <= b.lo[2];
    box_max_x <= b.hi[0];
    box_max_y <= b.hi[1];
    box_max_z <= b.hi[2];
    do @(posedge clk); while (busy);
  endtask

  task automatic send_directed(input logic [31:0] lx, input logic [31:0] ly,
                               input logic [31:0] lz, input logic [31:0] hx,
                               input logic [31:0] hy, input logic [31:0] hz);
    box_t b;
    b.lo = '{lx, ly, lz};
    b.hi = '{hx, hy, hz};
    send_box(b);
  endtask

  task automatic pause_sender(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Waits until every expected word has arrived, then lets the front part finish.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (cells_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bcie_pkg::REG_W-1:0] idx, input logic [31:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
  endtask

  // Programs all registers; only called while the block is idle.
  task automatic load_setting(input logic [31:0] ox, input logic [31:0] oy,
                              input logic [31:0] oz, input logic [31:0] ix,
                              input logic [31:0] iy, input logic [31:0] iz,
                              input logic [31:0] p);
    write_reg(bcie_pkg::REG_ORIGIN_X, ox);
    write_reg(bcie_pkg::REG_ORIGIN_Y, oy);
    write_reg(bcie_pkg::REG_ORIGIN_Z, oz);
    write_reg(bcie_pkg::REG_INV_X, ix);
    write_reg(bcie_pkg::REG_INV_Y, iy);
    write_reg(bcie_pkg::REG_INV_Z, iz);
    write_reg(bcie_pkg::REG_PAD, p);
    wr_en <= 1'b0;
    grid_org = '{longint'($signed(ox)), longint'($signed(oy)), longint'($signed(oz))};
    cell_len = '{cell_step(ix), cell_step(iy), cell_step(iz)};
  endtask

  // Random boxes with sender gaps of varied length and an occasional full drain.
  task automatic run_random(input int n, input int idle_pct);
    for (int i = 0; i < n; i++) begin
      send_box(make_box());
      if ($urandom_range(0, 99) < 3) begin
        drain_results();
      end else if ($urandom_range(0, 99) < idle_pct) begin
        pause_sender(($urandom_range(0, 3) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8));
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    box_min_x = '0;
    box_min_y = '0;
    box_min_z = '0;
    box_max_x = '0;
    box_max_y = '0;
    box_max_z = '0;
    wr_en     = 1'b0;
    wr_index  = '0;
    wr_data   = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed boxes with the reset grid: one cell per unit along every axis.
    send_directed(q16(1), q16(2), q16(3), q16(1), q16(2), q16(3));
    send_directed(q16(0), q16(0), q16(0), q16(2) - 1, q16(2) - 1, q16(2) - 1);
    send_directed(q16(10), q16(20), q16(30), q16(14) - 1, q16(24) - 1, q16(34) - 1);
    send_directed(q16(0), q16(5), q16(5), q16(100), q16(5), q16(5));
    send_directed(q16(5), q16(1), q16(1), q16(5) - 1, q16(1), q16(1));
    send_directed(q16(1), q16(1), q16(8), q16(1), q16(1), q16(7));
    send_directed(q16(-100), q16(-100), q16(-100), q16(-50), q16(-50), q16(-50));
    send_directed(q16(2000), q16(0), q16(0), q16(3000), q16(1), q16(0));
    send_directed(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_directed(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_directed(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_directed(32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000,
                  32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    send_directed(q16(1022), q16(2046), q16(2045), q16(1025), q16(2049), q16(2047));
    send_directed(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_directed(q16(3), 32'h0, q16(3), q16(3), 32'hFFFF_FFFF, q16(3));
    send_directed(q16(7), q16(10), q16(7), q16(7), q16(15) - 1, q16(7));
    send_directed(q16(7), q16(7), q16(10), q16(7), q16(7), q16(14) - 1);
    run_random(40, 0);
    drain_results();

    // Offset grid, coarse and fine cells, a little padding.
    load_setting(32'hFFFA_8000, 32'h0003_4000, 32'h0064_0000,
                 32'd32768, 32'd262144, 32'd21845, 32'd16384);
    run_random(60, 58);
    drain_results();

    // Extreme origins, extreme reciprocals with zero along z, largest padding.
    load_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h7FFF_FFFF);
    send_directed(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_directed(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_directed(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    run_random(20, 0);
    drain_results();

    // Zero reciprocal along x pins every x index to zero.
    load_setting(32'h0, 32'h0, 32'h0, 32'h0, 32'd65536, 32'd196608, 32'h0);
    send_directed(q16(-500), q16(3), q16(1), q16(900), q16(4), q16(2));
    send_directed(32'h7FFF_FFFF, q16(1), q16(1), 32'h7FFF_FFFF, q16(1), q16(1));
    run_random(70, 0);
    drain_results();

    // Eighth-unit cells on x, five-unit cells on y, grid pushed toward the top of z.
    load_setting(32'h0010_0000, 32'hFFF0_0000, 32'h7FFF_0000,
                 32'd524288, 32'd13107, 32'd65536, 32'h1);
    run_random(60, 33);
    drain_results();

    // Back to the reset grid.
    load_setting(32'h0, 32'h0, 32'h0, 32'd65536, 32'd65536, 32'd65536, 32'h0);
    run_random(60, 58);
    drain_results();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
